>>> rtl/mmle_pkg.sv
// Package for the multi-mode line encoder: line code numbers, symbol levels,
// the symbol job that travels from the front end to the back end, and sizes.
// Depends on nothing.
package mmle_pkg;

  // Line code register values. AMI and the two spare codes share one arm.
  localparam logic [2:0] CODE_NRZI       = 3'd0;
  localparam logic [2:0] CODE_MANCHESTER = 3'd1;
  localparam logic [2:0] CODE_DIFF_MANCH = 3'd2;
  localparam logic [2:0] CODE_B8ZS       = 3'd4;
  localparam logic [2:0] CODE_HDB3       = 3'd5;

  localparam int MAX_SYMBOLS   = 8;
  localparam int QUEUE_DEPTH   = 4;

  typedef logic signed [1:0] level_t;

  localparam level_t LEVEL_POS  = 2'sb01;
  localparam level_t LEVEL_ZERO = 2'sb00;
  localparam level_t LEVEL_NEG  = 2'sb11;

  // One input item's worth of line symbols, first symbol in lane zero.
  typedef struct packed {
    logic [3:0]                   count;
    level_t [MAX_SYMBOLS-1:0]     syms;
  } sym_job_t;

  function automatic level_t polarity(input logic positive);
    return positive ? LEVEL_POS : LEVEL_NEG;
  endfunction

endpackage

>>> rtl/multi_mode_line_encoder.sv
// Top level of the multi-mode line encoder (NRZ-I, Manchester, differential
// Manchester, AMI, B8ZS, HDB3). Depends on mmle_pkg, mmle_front, mmle_queue
// and mmle_back.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------
//   input    in_valid / in_stall    req_type, data_bit
//   output   out_valid / out_stall  level (signed), last_of_run
//   config   cfg_write_en           cfg_write_data (line code)
//
// An input item is taken whenever the job queue has room, so items may
// arrive on consecutive clocks.
// The back end sends one symbol per clock while the output is not stalled,
// so sustained rate is set by the symbol sequencer. The first symbol of an
// item appears after it is written into the queue and loaded by the back end.
// Reset is synchronous and returns the line code to NRZ-I and all coding
// state to its start values; there is no clearing pass.
// A stall on the output fills the queue and then stalls the input; items that
// produce no symbol still wait for room in the queue.
module multi_mode_line_encoder #(
  parameter int QUEUE_DEPTH = mmle_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [2:0]       cfg_write_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_type,
  input  logic             data_bit,
  output logic             out_valid,
  input  logic             out_stall,
  output mmle_pkg::level_t level,
  output logic             last_of_run
);
  import mmle_pkg::*;

  // Jobs carry the complete symbol sequence of one item, so the back end
  // needs no knowledge of the line code in force.
  sym_job_t front_job;
  sym_job_t head_job;
  logic     push;
  logic     pop;
  logic     queue_full;
  logic     queue_empty;

  // The input stalls only when the queue cannot take another transfer.
  assign in_stall = queue_full;

  mmle_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .req_type       (req_type),
    .data_bit       (data_bit),
    .queue_full     (queue_full),
    .push           (push),
    .job            (front_job)
  );

  mmle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  // The back end holds the current job in registers, which also serve as the
  // output stage: a stalled transfer keeps its symbol unchanged.
  mmle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .level       (level),
    .last_of_run (last_of_run)
  );

endmodule

>>> rtl/mmle_front.sv
// Front end of the line encoder: holds the line code register and the coding
// state, and turns each accepted item into a job of line symbols.
// Depends on mmle_pkg.
module mmle_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [2:0]        cfg_write_data,
  input  logic              in_valid,
  input  logic              req_type,
  input  logic              data_bit,
  input  logic              queue_full,
  output logic              push,
  output mmle_pkg::sym_job_t job
);
  import mmle_pkg::*;

  logic [2:0] line_code;
  logic       nrzi_level, nrzi_level_next;
  logic       dm_level, dm_level_next;
  logic       pulse_positive, pulse_positive_next;
  logic       hdb3_even, hdb3_even_next;
  logic [2:0] zero_run, zero_run_next;

  logic       accept;
  logic [3:0] run;
  logic [2:0] lead_zeros;
  logic [2:0] tail_len;
  level_t     tail [4];
  logic       b8zs_burst;
  logic       dm_first;
  level_t     next_pulse;

  assign accept     = in_valid && !queue_full;
  assign run        = {1'b0, zero_run} + 4'd1;
  assign next_pulse = pulse_positive ? LEVEL_NEG : LEVEL_POS;
  assign dm_first   = data_bit ? dm_level : !dm_level;

  always_comb begin
    nrzi_level_next     = nrzi_level;
    dm_level_next       = dm_level;
    pulse_positive_next = pulse_positive;
    hdb3_even_next      = hdb3_even;
    zero_run_next       = zero_run;
    lead_zeros          = 3'd0;
    tail_len            = 3'd0;
    b8zs_burst          = 1'b0;
    for (int t = 0; t < 4; t++) begin
      tail[t] = LEVEL_ZERO;
    end
    if (req_type) begin
      // End of stream: release the held zeros and return to the start state.
      lead_zeros          = zero_run;
      nrzi_level_next     = 1'b0;
      dm_level_next       = 1'b1;
      pulse_positive_next = 1'b0;
      hdb3_even_next      = 1'b1;
      zero_run_next       = 3'd0;
    end else begin
      unique case (line_code)
        CODE_NRZI: begin
          zero_run_next   = 3'd0;
          nrzi_level_next = nrzi_level ^ data_bit;
          tail[0]         = polarity(nrzi_level ^ data_bit);
          tail_len        = 3'd1;
        end
        CODE_MANCHESTER: begin
          zero_run_next = 3'd0;
          tail[0]       = polarity(data_bit);
          tail[1]       = polarity(!data_bit);
          tail_len      = 3'd2;
        end
        CODE_DIFF_MANCH: begin
          zero_run_next = 3'd0;
          tail[0]       = polarity(dm_first);
          tail[1]       = polarity(!dm_first);
          tail_len      = 3'd2;
          dm_level_next = !dm_first;
        end
        CODE_B8ZS: begin
          if (data_bit) begin
            lead_zeros          = zero_run;
            zero_run_next       = 3'd0;
            tail[0]             = next_pulse;
            tail_len            = 3'd1;
            pulse_positive_next = !pulse_positive;
          end else if (run >= 4'(MAX_SYMBOLS)) begin
            b8zs_burst    = 1'b1;
            zero_run_next = 3'd0;
          end else begin
            zero_run_next = run[2:0];
          end
        end
        CODE_HDB3: begin
          if (data_bit) begin
            lead_zeros          = zero_run;
            zero_run_next       = 3'd0;
            tail[0]             = next_pulse;
            tail_len            = 3'd1;
            pulse_positive_next = !pulse_positive;
            hdb3_even_next      = !hdb3_even;
          end else if (run >= 4'd4) begin
            // Any surplus left from a longer run is sent as plain zeros first.
            lead_zeros = 3'(run - 4'd4);
            tail_len   = 3'd4;
            if (hdb3_even) begin
              tail[0]             = polarity(!pulse_positive);
              tail[3]             = polarity(!pulse_positive);
              pulse_positive_next = !pulse_positive;
            end else begin
              tail[3] = polarity(pulse_positive);
            end
            hdb3_even_next = 1'b1;
            zero_run_next  = 3'd0;
          end else begin
            zero_run_next = run[2:0];
          end
        end
        default: begin
          // AMI, and the spare codes which behave as AMI.
          lead_zeros    = zero_run;
          zero_run_next = 3'd0;
          tail_len      = 3'd1;
          if (data_bit) begin
            tail[0]             = next_pulse;
            pulse_positive_next = !pulse_positive;
          end
        end
      endcase
    end
  end

  always_comb begin
    logic [3:0] k;
    k = 4'd0;
    if (b8zs_burst) begin
      job.count   = 4'(MAX_SYMBOLS);
      job.syms[0] = LEVEL_ZERO;
      job.syms[1] = LEVEL_ZERO;
      job.syms[2] = LEVEL_ZERO;
      job.syms[3] = polarity(pulse_positive);
      job.syms[4] = polarity(!pulse_positive);
      job.syms[5] = LEVEL_ZERO;
      job.syms[6] = polarity(!pulse_positive);
      job.syms[7] = polarity(pulse_positive);
    end else begin
      job.count = {1'b0, lead_zeros} + {1'b0, tail_len};
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        k = 4'(i) - {1'b0, lead_zeros};
        if (4'(i) < {1'b0, lead_zeros}) begin
          job.syms[i] = LEVEL_ZERO;
        end else if (k < {1'b0, tail_len}) begin
          job.syms[i] = tail[k[1:0]];
        end else begin
          job.syms[i] = LEVEL_ZERO;
        end
      end
    end
  end

  assign push = accept && (job.count != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_code      <= CODE_NRZI;
      nrzi_level     <= 1'b0;
      dm_level       <= 1'b1;
      pulse_positive <= 1'b0;
      hdb3_even      <= 1'b1;
      zero_run       <= 3'd0;
    end else begin
      if (cfg_write_en) begin
        line_code <= cfg_write_data;
      end
      if (accept) begin
        nrzi_level     <= nrzi_level_next;
        dm_level       <= dm_level_next;
        pulse_positive <= pulse_positive_next;
        hdb3_even      <= hdb3_even_next;
        zero_run       <= zero_run_next;
      end
    end
  end

endmodule

>>> rtl/mmle_queue.sv
// Short first-in first-out queue of symbol jobs between front and back end.
// Depends on mmle_pkg.
module mmle_queue #(
  parameter int DEPTH = mmle_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mmle_pkg::sym_job_t push_job,
  input  logic               pop,
  output mmle_pkg::sym_job_t head_job,
  output logic               full,
  output logic               empty
);
  import mmle_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sym_job_t           jobs [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign head_job = jobs[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      jobs[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("queue fill beyond depth");

endmodule

>>> rtl/mmle_back.sv
// Back end of the line encoder: takes jobs from the queue and sends their
// symbols one per clock on the output channel while it is not stalled. Depends on mmle_pkg.
module mmle_back (
  input  logic               clk,
  input  logic               rst,
  input  mmle_pkg::sym_job_t head_job,
  input  logic               queue_empty,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output mmle_pkg::level_t   level,
  output logic               last_of_run
);
  import mmle_pkg::*;

  sym_job_t   cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       fire;
  logic       load;

  assign out_valid   = cur_valid;
  assign level       = cur.syms[idx];
  assign last_of_run = ({1'b0, idx} == (cur.count - 4'd1));
  assign fire        = cur_valid && !out_stall;
  assign load        = !cur_valid || (fire && last_of_run);
  assign pop         = load && !queue_empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        cur_valid <= !queue_empty;
        idx       <= 3'd0;
      end else if (fire) begin
        idx <= idx + 3'd1;
      end
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != 4'd0) && ({1'b0, idx} < cur.count))
    else $error("symbol index outside the current job");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (fire && !last_of_run) |=> cur_valid && (idx == $past(idx) + 3'd1))
    else $error("symbol sequencer did not advance");
  a_level_code: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (level != 2'sb10))
    else $error("illegal line level");

endmodule
